// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression must hold on every edge outside reset
`define GOP_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("gate opener check failed");

// consequent must hold on the edge after the antecedent
`define GOP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gate opener sequence check failed");

`else

`define GOP_ASSERT_ALWAYS(label, clk, rst, expr)
`define GOP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/gop_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gop_pkg;

   localparam int unsigned COUNT_WIDTH_DEF = 16;
   localparam int unsigned CFG_WIDTH       = 16;
   localparam int unsigned CFG_IDX_WIDTH   = 3;

   // register indexes on the csr port
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_RUN_LIMIT       = 3'd0;
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_AUTOCLOSE_LIMIT = 3'd1;
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_FAST_BLINK      = 3'd2;
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_SLOW_BLINK      = 3'd3;
   localparam logic [CFG_IDX_WIDTH-1:0] CFG_ALARM_TOGGLE    = 3'd4;

   localparam logic [CFG_WIDTH-1:0] RUN_LIMIT_RST       = 16'd10;
   localparam logic [CFG_WIDTH-1:0] AUTOCLOSE_LIMIT_RST = 16'd5;
   localparam logic [CFG_WIDTH-1:0] FAST_BLINK_RST      = 16'd5;
   localparam logic [CFG_WIDTH-1:0] SLOW_BLINK_RST      = 16'd10;
   localparam logic [CFG_WIDTH-1:0] ALARM_TOGGLE_RST    = 16'd50;

   typedef enum logic [2:0] {
      ST_INIT    = 3'd0,
      ST_CLOSING = 3'd1,
      ST_OPENING = 3'd2,
      ST_CLOSED  = 3'd3,
      ST_OPEN    = 3'd4,
      ST_ERROR   = 3'd5,
      ST_STOP    = 3'd6
   } state_type;

   typedef enum logic [1:0] {
      FAULT_OK  = 2'd0,
      FAULT_LSW = 2'd1,
      FAULT_OT  = 2'd2
   } fault_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] run_limit;
      logic [CFG_WIDTH-1:0] autoclose_limit;
      logic [CFG_WIDTH-1:0] fast_blink_ticks;
      logic [CFG_WIDTH-1:0] slow_blink_ticks;
      logic [CFG_WIDTH-1:0] alarm_toggle_ticks;
   } cfg_type;

   // one scan tick
   typedef struct packed {
      logic limit_closed;
      logic limit_open;
      logic btn_open;
      logic btn_close;
      logic btn_toggle;
      logic cmd_reset;
   } word_type;

   typedef struct packed {
      logic motor_open;
      logic motor_close;
      logic lamp;
      logic buzzer;
   } step_type;

endpackage

`default_nettype wire

// ----- rtl/gop_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gop_fsm #(
   parameter int unsigned COUNT_WIDTH = gop_pkg::COUNT_WIDTH_DEF
) (
   input  gop_pkg::state_type        state,
   input  logic [COUNT_WIDTH-1:0]    run_count,
   input  logic [COUNT_WIDTH-1:0]    open_count,
   input  logic [COUNT_WIDTH-1:0]    blink_count,
   input  logic                      lamp,
   input  logic                      buzzer,
   input  gop_pkg::fault_type        fault,
   input  gop_pkg::word_type         word,
   input  gop_pkg::cfg_type          cfg,
   output gop_pkg::state_type        state_next,
   output gop_pkg::fault_type        fault_next,
   output logic [COUNT_WIDTH-1:0]    run_count_next,
   output logic [COUNT_WIDTH-1:0]    open_count_next,
   output logic [COUNT_WIDTH-1:0]    blink_count_next,
   output gop_pkg::step_type         step
);
   import gop_pkg::*;

   localparam int unsigned CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

   logic                   moving;
   logic                   closing;
   logic                   arrived;
   logic                   period_hit;
   logic                   overtime;
   logic                   autoclose;
   logic [COUNT_WIDTH-1:0] run_inc;
   logic [COUNT_WIDTH-1:0] open_inc;
   logic [COUNT_WIDTH-1:0] blink_inc;
   logic [CFG_WIDTH-1:0]   period;

   assign closing = (state == ST_CLOSING);
   assign moving  = closing || (state == ST_OPENING);
   assign arrived = closing ? word.limit_closed : word.limit_open;

   // saturating increments
   assign run_inc   = (&run_count)   ? run_count   : run_count + 1'b1;
   assign open_inc  = (&open_count)  ? open_count  : open_count + 1'b1;
   assign blink_inc = (&blink_count) ? blink_count : blink_count + 1'b1;

   always_comb begin
      case (state)
         ST_CLOSING: period = cfg.fast_blink_ticks;
         ST_OPENING: period = cfg.slow_blink_ticks;
         default:    period = cfg.alarm_toggle_ticks;
      endcase
   end

   assign period_hit = CMP_WIDTH'(blink_inc) >= CMP_WIDTH'(period);
   assign overtime   = CMP_WIDTH'(run_inc) > CMP_WIDTH'(cfg.run_limit);
   assign autoclose  = CMP_WIDTH'(open_inc) >= CMP_WIDTH'(cfg.autoclose_limit);

   // next state and fault
   always_comb begin
      state_next = state;
      fault_next = fault;
      case (state)
         ST_INIT: begin
            if (word.limit_closed && word.limit_open) begin
               fault_next = FAULT_LSW;
               state_next = ST_ERROR;
            end else if (word.limit_closed) begin
               state_next = ST_CLOSED;
            end else if (word.limit_open) begin
               state_next = ST_CLOSING;
            end else begin
               state_next = ST_STOP;
            end
         end
         ST_CLOSING, ST_OPENING: begin
            if (arrived) begin
               state_next = closing ? ST_CLOSED : ST_OPEN;
            end else if (word.btn_open || word.btn_close) begin
               state_next = ST_STOP;
            end else if (overtime) begin
               fault_next = FAULT_OT;
               state_next = ST_ERROR;
            end
         end
         ST_CLOSED: begin
            if (word.btn_open || word.btn_toggle) state_next = ST_OPENING;
         end
         ST_OPEN: begin
            if (word.btn_close || word.btn_toggle || autoclose) state_next = ST_CLOSING;
         end
         ST_ERROR: begin
            // limit fault clears once either switch lets go
            if (fault == FAULT_LSW && (!word.limit_closed || !word.limit_open)) begin
               fault_next = FAULT_OK;
               state_next = ST_INIT;
            end
         end
         ST_STOP: begin
            if (word.btn_close && !word.limit_closed) begin
               state_next = ST_CLOSING;
            end else if (word.btn_open && !word.limit_open) begin
               state_next = ST_OPENING;
            end else if (word.btn_toggle && !word.limit_open && !word.limit_closed) begin
               state_next = ST_CLOSING;
            end
         end
         default: state_next = ST_ERROR;
      endcase
      if (word.cmd_reset) begin
         fault_next = FAULT_OK;
         if (state == ST_ERROR) state_next = ST_INIT;
      end
   end

   // drives and counters
   always_comb begin
      step.motor_open  = (state == ST_OPENING);
      step.motor_close = closing;
      step.lamp        = lamp;
      step.buzzer      = buzzer;
      run_count_next   = run_count;
      open_count_next  = open_count;
      blink_count_next = blink_count;
      if (moving) begin
         run_count_next   = run_inc;
         step.buzzer      = 1'b1;
         blink_count_next = period_hit ? '0 : blink_inc;
         if (period_hit) step.lamp = ~lamp;
      end else if (state == ST_ERROR) begin
         blink_count_next = period_hit ? '0 : blink_inc;
         if (period_hit) step.buzzer = ~buzzer;
      end else if (state == ST_OPEN) begin
         step.lamp       = 1'b1;
         open_count_next = open_inc;
      end
      // counters restart on any change of state
      if (state_next != state) begin
         run_count_next   = '0;
         open_count_next  = '0;
         blink_count_next = '0;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/gate_opener_controller.sv -----
// a word accepted at one edge has its result on the rsp port after that edge
// throughput: one word per cycle while rsp_ready is high, the state update is a single pass between registers
// the rsp register takes the next result while the current one is being taken
// reset is synchronous and active high: gate sequence to initial, counters, lamp, buzzer
// and fault to zero, configuration back to its defaults, no result held
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gate_opener_controller #(
   parameter int unsigned COUNT_WIDTH = gop_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_limit_closed,
   input  logic                                req_limit_open,
   input  logic                                req_btn_open,
   input  logic                                req_btn_close,
   input  logic                                req_btn_toggle,
   input  logic                                req_cmd_reset,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_gate_state,
   output logic                                rsp_motor_open,
   output logic                                rsp_motor_close,
   output logic                                rsp_lamp,
   output logic                                rsp_buzzer,
   output logic [1:0]                          rsp_fault_code,
   input  logic                                csr_we,
   input  logic [gop_pkg::CFG_IDX_WIDTH-1:0]   csr_index,
   input  logic [gop_pkg::CFG_WIDTH-1:0]       csr_wdata
);
   import gop_pkg::*;

   state_type              state_ff;
   state_type              state_in;
   fault_type              fault_ff;
   fault_type              fault_in;
   logic [COUNT_WIDTH-1:0] run_count_ff;
   logic [COUNT_WIDTH-1:0] run_count_in;
   logic [COUNT_WIDTH-1:0] open_count_ff;
   logic [COUNT_WIDTH-1:0] open_count_in;
   logic [COUNT_WIDTH-1:0] blink_count_ff;
   logic [COUNT_WIDTH-1:0] blink_count_in;
   logic                   lamp_ff;
   logic                   buzzer_ff;
   cfg_type                cfg_ff;
   word_type               word;
   step_type               step;
   logic                   req_fire;
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_state_ff;
   logic                   rsp_motor_open_ff;
   logic                   rsp_motor_close_ff;
   logic                   rsp_lamp_ff;
   logic [1:0]             rsp_fault_code_ff;

   assign word = '{limit_closed: req_limit_closed, limit_open: req_limit_open,
                   btn_open: req_btn_open, btn_close: req_btn_close,
                   btn_toggle: req_btn_toggle, cmd_reset: req_cmd_reset};

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   gop_fsm #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_fsm (
      .state           (state_ff),
      .run_count       (run_count_ff),
      .open_count      (open_count_ff),
      .blink_count     (blink_count_ff),
      .lamp            (lamp_ff),
      .buzzer          (buzzer_ff),
      .fault           (fault_ff),
      .word            (word),
      .cfg             (cfg_ff),
      .state_next      (state_in),
      .fault_next      (fault_in),
      .run_count_next  (run_count_in),
      .open_count_next (open_count_in),
      .blink_count_next(blink_count_in),
      .step            (step)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.run_limit          <= RUN_LIMIT_RST;
         cfg_ff.autoclose_limit    <= AUTOCLOSE_LIMIT_RST;
         cfg_ff.fast_blink_ticks   <= FAST_BLINK_RST;
         cfg_ff.slow_blink_ticks   <= SLOW_BLINK_RST;
         cfg_ff.alarm_toggle_ticks <= ALARM_TOGGLE_RST;
      end else if (csr_we) begin
         case (csr_index)
            CFG_RUN_LIMIT:       cfg_ff.run_limit          <= csr_wdata;
            CFG_AUTOCLOSE_LIMIT: cfg_ff.autoclose_limit    <= csr_wdata;
            CFG_FAST_BLINK:      cfg_ff.fast_blink_ticks   <= csr_wdata;
            CFG_SLOW_BLINK:      cfg_ff.slow_blink_ticks   <= csr_wdata;
            CFG_ALARM_TOGGLE:    cfg_ff.alarm_toggle_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // gate state, advanced once per accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         fault_ff       <= FAULT_OK;
         run_count_ff   <= '0;
         open_count_ff  <= '0;
         blink_count_ff <= '0;
         lamp_ff        <= 1'b0;
         buzzer_ff      <= 1'b0;
      end else if (req_fire) begin
         state_ff       <= state_in;
         fault_ff       <= fault_in;
         run_count_ff   <= run_count_in;
         open_count_ff  <= open_count_in;
         blink_count_ff <= blink_count_in;
         lamp_ff        <= step.lamp;
         buzzer_ff      <= step.buzzer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_state_ff       <= state_in;
         rsp_motor_open_ff  <= step.motor_open;
         rsp_motor_close_ff <= step.motor_close;
         rsp_lamp_ff        <= step.lamp;
         rsp_fault_code_ff  <= fault_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_gate_state  = rsp_state_ff;
   assign rsp_motor_open  = rsp_motor_open_ff;
   assign rsp_motor_close = rsp_motor_close_ff;
   assign rsp_lamp        = rsp_lamp_ff;
   assign rsp_buzzer      = buzzer_ff;
   assign rsp_fault_code  = rsp_fault_code_ff;

   `GOP_ASSERT_ALWAYS(a_motor_excl, clock, reset,
                      !rsp_valid_ff || !(rsp_motor_open_ff && rsp_motor_close_ff))
   `GOP_ASSERT_ALWAYS(a_fault_in_error, clock, reset,
                      fault_ff == FAULT_OK || state_ff == ST_ERROR)
   `GOP_ASSERT_NEXT(a_count_restart, clock, reset, req_fire && (state_in != state_ff),
                    run_count_ff == '0 && open_count_ff == '0 && blink_count_ff == '0)

endmodule

`default_nettype wire
